FILE: design/sync_async_batch_dispatcher_macros.svh
// Assertion helpers for the dispatcher checker.
// Both expect clk and arst_n in scope.
`ifndef SYNC_ASYNC_BATCH_DISPATCHER_MACROS_SVH
`define SYNC_ASYNC_BATCH_DISPATCHER_MACROS_SVH

// Property sampled on the rising edge, off while in reset.
`define SABD_CHECK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("dispatcher check failed");

// A stalled result transfer keeps the given signal unchanged.
`define SABD_CHECK_HOLD(lbl, sig) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		(out_valid && out_stall) |=> $stable(sig)) \
		else $error("dispatcher output moved under stall");

`endif

FILE: design/sabd_pkg.sv
package sabd_pkg;

	// Field widths fixed by the interface
	localparam int TAG_W   = 16;
	localparam int KIND_W  = 2;
	localparam int RC_W    = 7;
	localparam int CFG_W   = 8;

	// Cap on tags sent by one dispatch
	localparam int MAX_RESULTS = 32;
	localparam int N_W         = $clog2(MAX_RESULTS + 1);

	// Operation codes
	localparam logic OP_ADD      = 1'b0;
	localparam logic OP_DISPATCH = 1'b1;

	// Configuration register indexes
	localparam logic CFG_SYNC_RATIO  = 1'b0;
	localparam logic CFG_BATCH_COUNT = 1'b1;

	// Configuration reset values
	localparam logic [CFG_W-1:0] SYNC_RATIO_RST  = 8'd4;
	localparam logic [CFG_W-1:0] BATCH_COUNT_RST = 8'd2;

	// Result kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_ADDED   = 2'd0,
		KIND_DROPPED = 2'd1,
		KIND_TAG     = 2'd2,
		KIND_EMPTY   = 2'd3
	} kind_t;

	// Queue control from the sequencer
	typedef struct packed {
		logic push;
		logic pop;
	} qctl_t;

endpackage

FILE: design/sabd_queue.sv
module sabd_queue import sabd_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  qctl_t                        ctl,
	input  logic [TAG_W-1:0]             wdata,
	output logic [TAG_W-1:0]             rdata,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	logic [TAG_W-1:0] mem_q [DEPTH];
	logic [AW-1:0]    head_q;
	logic [CW-1:0]    count_q;
	logic [SW-1:0]    tail_sum;
	logic [AW-1:0]    tail_idx;

	// Tail slot: head plus fill, wrapped once
	always_comb begin
		tail_sum = SW'(head_q) + SW'(count_q);
		if (tail_sum >= SW'(DEPTH)) begin
			tail_sum = tail_sum - SW'(DEPTH);
		end
		tail_idx = tail_sum[AW-1:0];
	end

	// Store on push
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem_q[tail_idx] <= wdata;
		end
	end

	// Advance head and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctl.pop) begin
				head_q  <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
				count_q <= count_q - CW'(1);
			end else if (ctl.push) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	assign rdata = mem_q[head_q];
	assign count = count_q;

endmodule

FILE: design/sync_async_batch_dispatcher.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------------
// in       | in_valid / in_stall  | op, is_sync, request_tag, force_req
// out      | out_valid / out_stall| kind, out_tag, from_sync, run_count, last
// cfg      | cfg_we               | cfg_index, cfg_data
//
// An add captures the request, then writes the queue and reports.
// A dispatch runs one sequencer step a cycle unless the output stalls, popping
// at most one tag per step; the last result leaves on the final step.
// Reset clears queue pointers and fills; queue contents are not cleared.
// A stall on the output holds the sequencer wherever it needs to send.
module sync_async_batch_dispatcher import sabd_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              op,
	input  logic              is_sync,
	input  logic [TAG_W-1:0]  request_tag,
	input  logic              force_req,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [KIND_W-1:0] kind,
	output logic [TAG_W-1:0]  out_tag,
	output logic              from_sync,
	output logic [RC_W-1:0]   run_count,
	output logic              last,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_SYNC,
		ST_ASYNC,
		ST_ROUND,
		ST_FSYNC,
		ST_FASYNC
	} state_t;

	state_t            state_q;
	logic [CFG_W-1:0]  ratio_q;
	logic [CFG_W-1:0]  batch_q;
	logic              is_sync_q;
	logic [TAG_W-1:0]  tag_q;
	logic [N_W-1:0]    n_q;
	logic [CFG_W-1:0]  j_q;
	logic [CFG_W-1:0]  round_q;
	logic              pend_valid_q;
	logic [TAG_W-1:0]  pend_tag_q;
	logic              pend_sync_q;
	logic [N_W-1:0]    pend_rc_q;
	logic              out_valid_q;
	kind_t             kind_q;
	logic [TAG_W-1:0]  out_tag_q;
	logic              from_sync_q;
	logic [RC_W-1:0]   run_count_q;
	logic              last_q;

	qctl_t             sync_ctl;
	qctl_t             async_ctl;
	logic [TAG_W-1:0]  sync_rdata;
	logic [TAG_W-1:0]  async_rdata;
	logic [CW-1:0]     sync_cnt;
	logic [CW-1:0]     async_cnt;

	logic              out_free;
	logic              n_room;
	logic              sync_full;
	logic              async_full;
	logic              pop_sync;
	logic              pop_async;
	logic              finish;
	logic              step_ok;
	logic              add_emit;
	logic [TAG_W-1:0]  pop_tag;

	sabd_queue #(.DEPTH(QUEUE_DEPTH)) u_sync_q (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sync_ctl),
		.wdata  (tag_q),
		.rdata  (sync_rdata),
		.count  (sync_cnt)
	);

	sabd_queue #(.DEPTH(QUEUE_DEPTH)) u_async_q (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (async_ctl),
		.wdata  (tag_q),
		.rdata  (async_rdata),
		.count  (async_cnt)
	);

	// Configuration registers; a zero batch count stores one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= SYNC_RATIO_RST;
			batch_q <= BATCH_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SYNC_RATIO:  ratio_q <= cfg_data;
				CFG_BATCH_COUNT: batch_q <= (cfg_data == '0) ? CFG_W'(1) : cfg_data;
				default:         ratio_q <= ratio_q;
			endcase
		end
	end

	// Decide this step of the sequencer
	always_comb begin
		out_free   = !out_valid_q || !out_stall;
		n_room     = n_q < N_W'(MAX_RESULTS);
		sync_full  = sync_cnt >= CW'(QUEUE_DEPTH);
		async_full = async_cnt >= CW'(QUEUE_DEPTH);
		pop_sync   = 1'b0;
		pop_async  = 1'b0;
		finish     = 1'b0;
		case (state_q)
			ST_SYNC:   pop_sync  = (j_q < ratio_q) && (sync_cnt != '0) && n_room;
			ST_ASYNC:  pop_async = (async_cnt != '0) && n_room;
			ST_ROUND:  finish    = (n_q == '0) || !n_room ||
				({1'b0, round_q} + (CFG_W+1)'(1) >= {1'b0, batch_q});
			ST_FSYNC:  pop_sync  = (sync_cnt != '0) && n_room;
			ST_FASYNC: begin
				pop_async = (async_cnt != '0) && n_room;
				finish    = !pop_async;
			end
			default:   finish    = 1'b0;
		endcase
		step_ok   = !pend_valid_q || out_free;
		add_emit  = (state_q == ST_ADD) && out_free;
		pop_tag   = pop_sync ? sync_rdata : async_rdata;

		sync_ctl.push  = add_emit && is_sync_q && !sync_full;
		sync_ctl.pop   = pop_sync && step_ok;
		async_ctl.push = add_emit && !is_sync_q && !async_full;
		async_ctl.pop  = pop_async && step_ok;
	end

	// Sequencer with registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			is_sync_q    <= 1'b0;
			tag_q        <= '0;
			n_q          <= '0;
			j_q          <= '0;
			round_q      <= '0;
			pend_valid_q <= 1'b0;
			pend_tag_q   <= '0;
			pend_sync_q  <= 1'b0;
			pend_rc_q    <= '0;
			out_valid_q  <= 1'b0;
			kind_q       <= KIND_EMPTY;
			out_tag_q    <= '0;
			from_sync_q  <= 1'b0;
			run_count_q  <= '0;
			last_q       <= 1'b0;
		end else begin
			// drop the result once it is taken
			if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			// pop one tag; send the held one ahead of it
			if ((pop_sync || pop_async) && step_ok) begin
				if (pend_valid_q) begin
					out_valid_q <= 1'b1;
					kind_q      <= KIND_TAG;
					out_tag_q   <= pend_tag_q;
					from_sync_q <= pend_sync_q;
					run_count_q <= RC_W'(pend_rc_q);
					last_q      <= 1'b0;
				end
				pend_valid_q <= 1'b1;
				pend_tag_q   <= pop_tag;
				pend_sync_q  <= pop_sync;
				pend_rc_q    <= n_q + N_W'(1);
				n_q          <= n_q + N_W'(1);
			end

			// close the run with the held tag or an empty result
			if (finish && out_free) begin
				out_valid_q  <= 1'b1;
				last_q       <= 1'b1;
				pend_valid_q <= 1'b0;
				if (pend_valid_q) begin
					kind_q      <= KIND_TAG;
					out_tag_q   <= pend_tag_q;
					from_sync_q <= pend_sync_q;
					run_count_q <= RC_W'(pend_rc_q);
				end else begin
					kind_q      <= KIND_EMPTY;
					out_tag_q   <= '0;
					from_sync_q <= 1'b0;
					run_count_q <= '0;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						is_sync_q    <= is_sync;
						tag_q        <= request_tag;
						n_q          <= '0;
						j_q          <= '0;
						round_q      <= '0;
						pend_valid_q <= 1'b0;
						if (op == OP_ADD) begin
							state_q <= ST_ADD;
						end else begin
							state_q <= force_req ? ST_FSYNC : ST_SYNC;
						end
					end
				end
				ST_ADD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= (is_sync_q ? sync_full : async_full) ?
							KIND_DROPPED : KIND_ADDED;
						out_tag_q   <= tag_q;
						from_sync_q <= is_sync_q;
						run_count_q <= '0;
						last_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_SYNC: begin
					if (pop_sync) begin
						if (step_ok) begin
							j_q <= j_q + CFG_W'(1);
						end
					end else begin
						state_q <= ST_ASYNC;
					end
				end
				ST_ASYNC: begin
					if (!pop_async || step_ok) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					if (finish) begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end
					end else begin
						round_q <= round_q + CFG_W'(1);
						j_q     <= '0;
						state_q <= ST_SYNC;
					end
				end
				ST_FSYNC: begin
					if (!pop_sync) begin
						state_q <= ST_FASYNC;
					end
				end
				ST_FASYNC: begin
					if (finish && out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign out_tag   = out_tag_q;
	assign from_sync = from_sync_q;
	assign run_count = run_count_q;
	assign last      = last_q;

endmodule

FILE: design/sabd_checker.sv
`include "sync_async_batch_dispatcher_macros.svh"

module sabd_checker import sabd_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [KIND_W-1:0] kind,
	input logic [TAG_W-1:0]  out_tag,
	input logic              from_sync,
	input logic [RC_W-1:0]   run_count,
	input logic              last
);

	logic add_kind;
	logic empty_ok;
	logic count_ok;

	// classify the result on the port
	assign add_kind = (kind == KIND_ADDED) || (kind == KIND_DROPPED);
	assign empty_ok = last && (out_tag == '0) && (run_count == '0) && !from_sync;
	assign count_ok = (run_count != '0) && (run_count <= RC_W'(MAX_RESULTS));

	// busy straight after an item is taken
	`SABD_CHECK(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall)
	// add results are single and carry no run count
	`SABD_CHECK(a_add_single, (out_valid && add_kind) |-> (last && run_count == '0))
	// an empty dispatch reports zeros and ends the item
	`SABD_CHECK(a_empty_zero, (out_valid && kind == KIND_EMPTY) |-> empty_ok)
	// dispatched tags count from one up to the cap
	`SABD_CHECK(a_tag_count, (out_valid && kind == KIND_TAG) |-> count_ok)
	// a stalled result keeps its tag
	`SABD_CHECK_HOLD(a_tag_hold, out_tag)

endmodule

bind sync_async_batch_dispatcher sabd_checker u_sabd_checker (.*);
